FILE: rtl/aesctr_pkg.sv
// shared types, constants and aes round functions for the ctr packet cipher
package aesctr_pkg;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned PtrWidth = $clog2(QueueDepth);

   typedef enum logic [2:0] {
      REG_KEY_WORD_0 = 3'd0,
      REG_KEY_WORD_1 = 3'd1,
      REG_KEY_WORD_2 = 3'd2,
      REG_KEY_WORD_3 = 3'd3,
      REG_KEY_IS_WIDE = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [7:0] cipher_byte;
      logic last;
      logic need_block;
      logic [3:0] offset;
      logic [127:0] counter;
   } entry_type;

   typedef struct packed {
      logic [255:0] key;
      logic wide;
   } key_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   function automatic logic [7:0] xt(input logic [7:0] v);
      return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // next four words of the aes-128 schedule
   function automatic logic [127:0] next_key_128(input logic [127:0] w, input logic [7:0] rc);
      logic [31:0] t, n0, n1, n2, n3;
      t = sub_word({w[23:0], w[31:24]}) ^ {rc, 24'h0};
      n0 = w[127:96] ^ t;
      n1 = w[95:64] ^ n0;
      n2 = w[63:32] ^ n1;
      n3 = w[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   // next four words of the aes-256 schedule from the previous eight
   function automatic logic [127:0] next_key_256(input logic [127:0] a, input logic [127:0] b,
                                                 input logic [7:0] rc, input logic odd);
      logic [31:0] t, n0, n1, n2, n3;
      t = odd ? sub_word(b[31:0]) : (sub_word({b[23:0], b[31:24]}) ^ {rc, 24'h0});
      n0 = a[127:96] ^ t;
      n1 = a[95:64] ^ n0;
      n2 = a[63:32] ^ n1;
      n3 = a[31:0] ^ n2;
      return {n0, n1, n2, n3};
   endfunction

   // subbytes, shiftrows and, except in the final round, mixcolumns
   function automatic logic [127:0] aes_round(input logic [127:0] st, input logic final_rnd);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] r;
      r = '0;
      for (int i = 0; i < 16; i++) begin
         t[i] = SBOX[st[127 - 8 * ((4 * (((i >> 2) + (i & 3)) & 3)) + (i & 3)) -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         a0 = t[4 * c];
         a1 = t[4 * c + 1];
         a2 = t[4 * c + 2];
         a3 = t[4 * c + 3];
         if (final_rnd) begin
            r[127 - 32 * c -: 32] = {a0, a1, a2, a3};
         end else begin
            r[127 - 32 * c -: 32] = {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                                     a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                                     a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                                     xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
         end
      end
      return r;
   endfunction

endpackage

FILE: rtl/aesctr_front.sv
// front end: accepts payload beats, tracks counter and byte offset, queues work
module aesctr_front (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [31:0] req_packet_id,
   input  logic [31:0] req_source_id,
   input  logic [7:0] req_cipher_byte,
   input  logic req_first_of_packet,
   input  logic req_last_of_packet,
   input  logic q_full,
   output logic q_push,
   output aesctr_pkg::entry_type q_entry
);
   import aesctr_pkg::*;

   logic [127:0] ctr_ff, ctr_in, ctr_eff;
   logic [3:0] off_ff, off_in, off_eff;
   logic need;

   assign req_ready = !q_full;
   assign q_push = req_valid && !q_full;

   always_comb begin
      if (req_first_of_packet) begin
         ctr_eff = {req_packet_id[7:0], req_packet_id[15:8], req_packet_id[23:16],
                    req_packet_id[31:24], 32'h0,
                    req_source_id[7:0], req_source_id[15:8], req_source_id[23:16],
                    req_source_id[31:24], 32'h0};
         off_eff = 4'd0;
      end else begin
         ctr_eff = ctr_ff;
         off_eff = off_ff;
      end
      need = (off_eff == 4'd0);
      ctr_in = need ? ctr_eff + 128'd1 : ctr_eff;
      off_in = off_eff + 4'd1;
      q_entry.cipher_byte = req_cipher_byte;
      q_entry.last = req_last_of_packet;
      q_entry.need_block = need;
      q_entry.offset = off_eff;
      q_entry.counter = ctr_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctr_ff <= '0;
         off_ff <= '0;
      end else if (q_push) begin
         ctr_ff <= ctr_in;
         off_ff <= off_in;
      end
   end

endmodule

FILE: rtl/aesctr_queue.sv
// short queue of work entries between front and back end
module aesctr_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  aesctr_pkg::entry_type push_entry,
   output logic full,
   input  logic pop,
   output logic empty,
   output aesctr_pkg::entry_type head
);
   import aesctr_pkg::*;

   entry_type mem_ff [QueueDepth];
   logic [PtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PtrWidth:0] count_ff;

   assign full = (count_ff == (PtrWidth + 1)'(QueueDepth));
   assign empty = (count_ff == '0);
   assign head = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (PtrWidth + 1)'(push) - (PtrWidth + 1)'(pop);
      end
   end

endmodule

FILE: rtl/aesctr_back.sv
// back end: round-per-cycle aes engine, keystream store and result register
module aesctr_back (
   input  logic clock,
   input  logic reset,
   input  aesctr_pkg::key_type key,
   input  logic q_empty,
   input  aesctr_pkg::entry_type q_head,
   output logic q_pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [7:0] rsp_plain_byte,
   output logic rsp_last_byte
);
   import aesctr_pkg::*;

   typedef enum logic {
      IDLE,
      RUN
   } state_type;

   state_type state_ff;
   logic [127:0] st_ff, st_in;
   logic [127:0] wa_ff, wb_ff, rk;
   logic [127:0] next128, next256;
   logic [7:0] rc_ff;
   logic phase_ff;
   logic [3:0] round_ff, nr;
   logic done_ff;
   logic [7:0] ks_ff [16];
   logic out_free, start;
   logic out_v_ff;
   logic [7:0] out_byte_ff;
   logic out_last_ff;

   assign nr = key.wide ? 4'd14 : 4'd10;
   assign out_free = !out_v_ff || rsp_ready;
   assign start = (state_ff == IDLE) && !q_empty && q_head.need_block && !done_ff;
   assign q_pop = (state_ff == IDLE) && !q_empty && (!q_head.need_block || done_ff) && out_free;

   assign next128 = next_key_128(wa_ff, rc_ff);
   assign next256 = next_key_256(wa_ff, wb_ff, rc_ff, phase_ff);
   assign rk = key.wide ? wb_ff : next128;
   assign st_in = aes_round(st_ff, round_ff == nr) ^ rk;

   assign rsp_valid = out_v_ff;
   assign rsp_plain_byte = out_byte_ff;
   assign rsp_last_byte = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         done_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  st_ff <= q_head.counter ^ key.key[255:128];
                  wa_ff <= key.key[255:128];
                  wb_ff <= key.key[127:0];
                  rc_ff <= 8'h01;
                  phase_ff <= 1'b0;
                  round_ff <= 4'd1;
                  state_ff <= RUN;
               end
               if (q_pop) begin
                  done_ff <= 1'b0;
               end
            end
            RUN: begin
               st_ff <= st_in;
               round_ff <= round_ff + 4'd1;
               if (key.wide) begin
                  wa_ff <= wb_ff;
                  wb_ff <= next256;
                  phase_ff <= !phase_ff;
                  if (!phase_ff) begin
                     rc_ff <= xt(rc_ff);
                  end
               end else begin
                  wa_ff <= next128;
                  rc_ff <= xt(rc_ff);
               end
               if (round_ff == nr) begin
                  for (int i = 0; i < 16; i++) begin
                     ks_ff[i] <= st_in[127 - 8 * i -: 8];
                  end
                  done_ff <= 1'b1;
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
         if (q_pop) begin
            out_v_ff <= 1'b1;
            out_byte_ff <= q_head.cipher_byte ^ ks_ff[q_head.offset];
            out_last_ff <= q_head.last;
         end else if (rsp_ready) begin
            out_v_ff <= 1'b0;
         end
      end
   end

endmodule

FILE: rtl/aes_ctr_packet_decrypt.sv
// Packet payload cipher using AES-128/256 in counter mode, one byte per beat. Bytes
// that continue a keystream block pass at one per cycle while the output is not
// stalled. A byte that opens a block (offset zero, or a first-of-packet mark) waits
// for the AES engine, which runs one round per cycle with the key schedule expanded
// on the fly over Nr rounds, Nr being 10 or 14. A two-beat queue separates the input
// side from the engine and the result register. Key registers are written through
// the csr port while the block is idle; the user ensures this, the block does not.
module aes_ctr_packet_decrypt (
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [63:0] csr_wr_data,
   input  logic req_valid,
   output logic req_ready,
   input  logic [31:0] req_packet_id,
   input  logic [31:0] req_source_id,
   input  logic [7:0] req_cipher_byte,
   input  logic req_first_of_packet,
   input  logic req_last_of_packet,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [7:0] rsp_plain_byte,
   output logic rsp_last_byte
);
   import aesctr_pkg::*;

   logic [63:0] kw_ff [4];
   logic wide_ff;
   key_type key;
   logic q_full, q_push, q_pop, q_empty;
   entry_type q_entry, q_head;

   assign key.key = {kw_ff[0], kw_ff[1], kw_ff[2], kw_ff[3]};
   assign key.wide = wide_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            kw_ff[i] <= '0;
         end
         wide_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_KEY_WORD_0: kw_ff[0] <= csr_wr_data;
            REG_KEY_WORD_1: kw_ff[1] <= csr_wr_data;
            REG_KEY_WORD_2: kw_ff[2] <= csr_wr_data;
            REG_KEY_WORD_3: kw_ff[3] <= csr_wr_data;
            REG_KEY_IS_WIDE: wide_ff <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   aesctr_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_packet_id(req_packet_id),
      .req_source_id(req_source_id),
      .req_cipher_byte(req_cipher_byte),
      .req_first_of_packet(req_first_of_packet),
      .req_last_of_packet(req_last_of_packet),
      .q_full(q_full),
      .q_push(q_push),
      .q_entry(q_entry)
   );

   aesctr_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_entry(q_entry),
      .full(q_full),
      .pop(q_pop),
      .empty(q_empty),
      .head(q_head)
   );

   aesctr_back u_back (
      .clock(clock),
      .reset(reset),
      .key(key),
      .q_empty(q_empty),
      .q_head(q_head),
      .q_pop(q_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_plain_byte(rsp_plain_byte),
      .rsp_last_byte(rsp_last_byte)
   );

endmodule
